### hw/rtl/assert_macros.svh
// Assertion macros shared by the sparse polynomial multiplier RTL.
// Every macro samples on the rising edge of clock and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SPM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spm assertion failed");

// Next-cycle implication.
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spm assertion failed");

// Condition that must never occur.
`define SPM_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("spm assertion failed");

`endif

### hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Constants, codes and shared types of the sparse polynomial multiplier.
// ----------------------------------------------------------------------------
package spm_pkg;

   // Capacity of the first-polynomial store and largest accepted exponent
   localparam int MAX_TERMS    = 64;
   localparam int MAX_EXPONENT = 255;

   // Field widths of the transactions
   localparam int COEFF_W   = 16;
   localparam int EXP_W     = 8;
   localparam int SUM_W     = 44;
   localparam int RES_EXP_W = 9;
   localparam int PROD_W    = 2 * COEFF_W;

   // Accumulator geometry
   localparam int SUM_SLOTS = 2 * MAX_EXPONENT + 2;
   localparam int SLOT_W    = $clog2(SUM_SLOTS);
   localparam int CURSOR_W  = SLOT_W + 1;
   localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(SUM_SLOTS - 1);

   // Term store geometry
   localparam int IDX_W   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int COUNT_W = $clog2(MAX_TERMS + 1);

   typedef enum logic [1:0] {
      FUNC_CLEAR       = 2'd0,
      FUNC_LOAD_FIRST  = 2'd1,
      FUNC_LOAD_SECOND = 2'd2,
      FUNC_FETCH       = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Command to the term store
   typedef struct packed {
      logic                       clear;
      logic                       load;
      logic signed [COEFF_W-1:0]  coeff;
      logic [EXP_W-1:0]           exponent;
   } term_cmd_type;

   // Term read out of the store
   typedef struct packed {
      logic                       valid;
      logic signed [COEFF_W-1:0]  coeff;
      logic [EXP_W-1:0]           exponent;
   } term_type;

   // One access to the accumulator memory
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } sum_access_type;

   // Exponent accepted by the loads
   function automatic logic exp_in_range(logic [EXP_W-1:0] e);
      return int'(e) <= MAX_EXPONENT;
   endfunction

endpackage

### hw/rtl/spm_term_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_term_store
// Memory of first-polynomial terms with fill count and sticky overflow flag.
// ----------------------------------------------------------------------------
module spm_term_store (
   input  logic                           clock,
   input  logic                           reset,
   input  spm_pkg::term_cmd_type          cmd,
   input  logic                           rd_en,
   input  logic [spm_pkg::IDX_W-1:0]      rd_idx,
   output spm_pkg::term_type              rd_term,
   output logic [spm_pkg::COUNT_W-1:0]    count,
   output logic                           dropped
);

   logic [spm_pkg::COEFF_W+spm_pkg::EXP_W-1:0] term_mem [spm_pkg::MAX_TERMS];

   logic [spm_pkg::COUNT_W-1:0]                count_ff, count_in;
   logic                                       dropped_ff, dropped_in;
   logic                                       rd_valid_ff;
   logic [spm_pkg::COEFF_W+spm_pkg::EXP_W-1:0] rd_data_ff;
   logic                                       full;

   assign full = (count_ff == spm_pkg::COUNT_W'(spm_pkg::MAX_TERMS));

   // Advance the count on a stored term, raise the flag on a full store, clear both on a clear
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.load) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + spm_pkg::COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
         rd_valid_ff <= rd_en;
      end
   end

   // Write the new term at the fill position
   always_ff @(posedge clock) begin
      if (cmd.load && !cmd.clear && !full) begin
         term_mem[count_ff[spm_pkg::IDX_W-1:0]] <= {cmd.coeff, cmd.exponent};
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= term_mem[rd_idx];
      end
   end

   assign rd_term.valid    = rd_valid_ff;
   assign rd_term.coeff    = rd_data_ff[spm_pkg::COEFF_W+spm_pkg::EXP_W-1:spm_pkg::EXP_W];
   assign rd_term.exponent = rd_data_ff[spm_pkg::EXP_W-1:0];
   assign count            = count_ff;
   assign dropped          = dropped_ff;

endmodule

### hw/rtl/spm_accum.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// spm_accum
// Accumulator memory indexed by exponent, with a two-stage multiply-add
// read-modify-write pipeline, write-back forwarding, clear sweep and scan read.
// ----------------------------------------------------------------------------
module spm_accum (
   input  logic                                   clock,
   input  logic                                   reset,
   input  spm_pkg::term_type                      mac_term,
   input  logic signed [spm_pkg::COEFF_W-1:0]     mul_coeff,
   input  logic [spm_pkg::EXP_W-1:0]              mul_exponent,
   input  spm_pkg::sum_access_type                clr,
   input  spm_pkg::sum_access_type                scan,
   output logic [spm_pkg::SUM_W-1:0]              rd_data,
   output logic                                   busy
);

   logic [spm_pkg::SUM_W-1:0]         sum_mem [spm_pkg::SUM_SLOTS];

   logic [spm_pkg::EXP_W:0]           slot_sum;
   logic [spm_pkg::SLOT_W-1:0]        slot;
   logic                              rd_en;
   logic [spm_pkg::SLOT_W-1:0]        rd_addr;
   logic [spm_pkg::SUM_W-1:0]         rd_data_ff;

   logic                              s2_valid_ff;
   logic [spm_pkg::SLOT_W-1:0]        s2_slot_ff;
   logic signed [spm_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic                              wb_valid_ff;
   logic [spm_pkg::SLOT_W-1:0]        wb_slot_ff;
   logic [spm_pkg::SUM_W-1:0]         wb_data_ff;

   logic [spm_pkg::SUM_W-1:0]         base;
   logic [spm_pkg::SUM_W-1:0]         prod_ext;
   logic [spm_pkg::SUM_W-1:0]         sum_new;

   // Stage one: slot from the exponent sum, product of the coefficients
   assign slot_sum = {1'b0, mac_term.exponent} + {1'b0, mul_exponent};
   assign slot     = spm_pkg::SLOT_W'(slot_sum);
   assign prod_in  = mac_term.coeff * mul_coeff;

   // Share the read port between the pipeline and the scan
   assign rd_en   = mac_term.valid | scan.en;
   assign rd_addr = mac_term.valid ? slot : scan.addr;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= sum_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= mac_term.valid;
         wb_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_slot_ff <= slot;
      prod_ff    <= prod_in;
      wb_slot_ff <= s2_slot_ff;
      wb_data_ff <= sum_new;
   end

   // Stage two: forward the previous write when it hit the same slot
   assign base     = (wb_valid_ff && (wb_slot_ff == s2_slot_ff)) ? wb_data_ff : rd_data_ff;
   assign prod_ext = {{(spm_pkg::SUM_W-spm_pkg::PROD_W){prod_ff[spm_pkg::PROD_W-1]}}, prod_ff};
   assign sum_new  = base + prod_ext;

   // Write back the sum, or zero an entry during the clear sweep
   always_ff @(posedge clock) begin
      if (clr.en) begin
         sum_mem[clr.addr] <= '0;
      end else if (s2_valid_ff) begin
         sum_mem[s2_slot_ff] <= sum_new;
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = s2_valid_ff;

   `SPM_ASSERT_NEVER(a_clear_during_mac, clr.en && (s2_valid_ff || mac_term.valid))
   `SPM_ASSERT_NEVER(a_scan_during_mac, scan.en && (mac_term.valid || s2_valid_ff))
   `SPM_ASSERT_NEXT(a_stage_follows, mac_term.valid, s2_valid_ff)

endmodule

### hw/rtl/sparse_polynomial_multiplier.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// sparse_polynomial_multiplier
// Sparse polynomial multiplier: controller, handshakes and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transaction: clear, load a first-polynomial
//   term, load a second-polynomial term, or fetch the next result term.
//   Only a fetch returns a transaction on rsp_*: the next nonzero term from
//   the highest exponent down, or term_found low once none remain.
//   A first-term load leaves req_ready high for the next transaction. A
//   second-term load walks the stored first terms, one multiply-add per
//   cycle through the accumulator memory, with req_ready low until the walk
//   and its drain are done.
//   A fetch scans the accumulator memory one slot per cycle from its cursor
//   until it finds a nonzero slot or passes the lowest one, through the single
//   read port of that memory.
//   Reset and a clear command both sweep the 512 accumulator slots to zero,
//   one slot per cycle, with req_ready low.
//   A result waits in an output register while rsp_ready is low; loads and
//   clears are still accepted meanwhile, and a further fetch finishes its scan
//   but holds its result until the register frees up.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiplier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic signed [spm_pkg::COEFF_W-1:0]   req_term_coeff,
   input  logic [spm_pkg::EXP_W-1:0]            req_term_exponent,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [spm_pkg::SUM_W-1:0]     rsp_result_coeff,
   output logic [spm_pkg::RES_EXP_W-1:0]        rsp_result_exponent,
   output logic                                 rsp_term_found,
   output logic                                 rsp_terms_dropped
);

   spm_pkg::state_type               state_ff, state_in;
   spm_pkg::func_type                func;
   logic                             req_fire;
   logic                             fetch_fire;
   logic                             exp_ok;

   logic [spm_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [spm_pkg::SLOT_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [spm_pkg::CURSOR_W-1:0]     cursor_ff, cursor_in;
   logic                             chk_valid_ff;
   logic [spm_pkg::SLOT_W-1:0]       chk_addr_ff;
   logic signed [spm_pkg::COEFF_W-1:0] coeff2_ff;
   logic [spm_pkg::EXP_W-1:0]        exp2_ff;

   logic [spm_pkg::SUM_W-1:0]        res_coeff_ff;
   logic [spm_pkg::RES_EXP_W-1:0]    res_exp_ff;
   logic                             res_found_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [spm_pkg::SUM_W-1:0]        rsp_coeff_ff;
   logic [spm_pkg::RES_EXP_W-1:0]    rsp_exp_ff;
   logic                             rsp_found_ff;
   logic                             rsp_dropped_ff;

   spm_pkg::term_cmd_type            term_cmd;
   spm_pkg::term_type                mac_term;
   spm_pkg::sum_access_type          clr_acc;
   spm_pkg::sum_access_type          scan_acc;
   logic [spm_pkg::COUNT_W-1:0]      term_count;
   logic                             terms_dropped;
   logic [spm_pkg::SUM_W-1:0]        sum_rd_data;
   logic                             accum_busy;

   logic                             term_rd_en;
   logic                             mac_start;
   logic                             mac_last;
   logic                             hit;
   logic                             scan_done;
   logic                             out_free;
   logic                             emit_load;

   assign func       = spm_pkg::func_type'(req_func);
   assign req_fire   = req_valid & req_ready;
   assign fetch_fire = req_fire && (func == spm_pkg::FUNC_FETCH);
   assign exp_ok     = spm_pkg::exp_in_range(req_term_exponent);

   assign mac_start = (func == spm_pkg::FUNC_LOAD_SECOND) && exp_ok && (term_count != '0);
   assign mac_last  = (spm_pkg::COUNT_W'(idx_ff) + spm_pkg::COUNT_W'(1)) == term_count;
   assign hit       = chk_valid_ff && (sum_rd_data != '0);
   assign scan_done = hit || cursor_ff[spm_pkg::CURSOR_W-1];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spm_pkg::ST_CLEAR: begin
            if (clr_addr_ff == spm_pkg::TOP_SLOT) state_in = spm_pkg::ST_IDLE;
         end
         spm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (func)
                  spm_pkg::FUNC_CLEAR:       state_in = spm_pkg::ST_CLEAR;
                  spm_pkg::FUNC_LOAD_FIRST:  state_in = spm_pkg::ST_IDLE;
                  spm_pkg::FUNC_LOAD_SECOND: state_in = mac_start ? spm_pkg::ST_MAC
                                                                  : spm_pkg::ST_IDLE;
                  spm_pkg::FUNC_FETCH:       state_in = spm_pkg::ST_SCAN;
                  default:                   state_in = spm_pkg::ST_IDLE;
               endcase
            end
         end
         spm_pkg::ST_MAC: begin
            if (mac_last) state_in = spm_pkg::ST_DRAIN;
         end
         spm_pkg::ST_DRAIN: begin
            if (!mac_term.valid && !accum_busy) state_in = spm_pkg::ST_IDLE;
         end
         spm_pkg::ST_SCAN: begin
            if (scan_done) state_in = spm_pkg::ST_EMIT;
         end
         spm_pkg::ST_EMIT: begin
            if (out_free) state_in = spm_pkg::ST_IDLE;
         end
         default: state_in = spm_pkg::ST_CLEAR;
      endcase
   end

   // Outputs of the controller
   always_comb begin
      req_ready     = 1'b0;
      term_rd_en    = 1'b0;
      clr_acc.en    = 1'b0;
      clr_acc.addr  = clr_addr_ff;
      scan_acc.en   = 1'b0;
      scan_acc.addr = cursor_ff[spm_pkg::SLOT_W-1:0];
      emit_load     = 1'b0;
      unique case (state_ff)
         spm_pkg::ST_CLEAR: clr_acc.en  = 1'b1;
         spm_pkg::ST_IDLE:  req_ready   = 1'b1;
         spm_pkg::ST_MAC:   term_rd_en  = 1'b1;
         spm_pkg::ST_DRAIN: ;
         spm_pkg::ST_SCAN:  scan_acc.en = !cursor_ff[spm_pkg::CURSOR_W-1] && !hit;
         spm_pkg::ST_EMIT:  emit_load   = out_free;
         default: ;
      endcase
   end

   // Term store commands
   assign term_cmd.clear    = req_fire && (func == spm_pkg::FUNC_CLEAR);
   assign term_cmd.load     = req_fire && (func == spm_pkg::FUNC_LOAD_FIRST) && exp_ok;
   assign term_cmd.coeff    = req_term_coeff;
   assign term_cmd.exponent = req_term_exponent;

   // Counters and the read cursor
   always_comb begin
      idx_in      = (state_ff == spm_pkg::ST_MAC) ? idx_ff + spm_pkg::IDX_W'(1) : '0;
      clr_addr_in = (state_ff == spm_pkg::ST_CLEAR) ? clr_addr_ff + spm_pkg::SLOT_W'(1) : '0;
      cursor_in   = cursor_ff;
      if (req_fire && (func != spm_pkg::FUNC_FETCH)) begin
         cursor_in = spm_pkg::CURSOR_W'(spm_pkg::TOP_SLOT);
      end else if (state_ff == spm_pkg::ST_SCAN) begin
         if (hit) begin
            cursor_in = spm_pkg::CURSOR_W'(chk_addr_ff) - spm_pkg::CURSOR_W'(1);
         end else if (!cursor_ff[spm_pkg::CURSOR_W-1]) begin
            cursor_in = cursor_ff - spm_pkg::CURSOR_W'(1);
         end
      end
   end

   assign rsp_valid_in = emit_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spm_pkg::ST_CLEAR;
         idx_ff       <= '0;
         clr_addr_ff  <= '0;
         cursor_ff    <= spm_pkg::CURSOR_W'(spm_pkg::TOP_SLOT);
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_addr_ff  <= clr_addr_in;
         cursor_ff    <= cursor_in;
         chk_valid_ff <= scan_acc.en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the second term, scan position and scan outcome
   always_ff @(posedge clock) begin
      chk_addr_ff <= scan_acc.addr;
      if (req_fire) begin
         coeff2_ff <= req_term_coeff;
         exp2_ff   <= req_term_exponent;
      end
      if ((state_ff == spm_pkg::ST_SCAN) && scan_done) begin
         res_found_ff <= hit;
         res_coeff_ff <= hit ? sum_rd_data : '0;
         res_exp_ff   <= hit ? spm_pkg::RES_EXP_W'(chk_addr_ff) : '0;
      end
   end

   // Output register: load when free, hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_coeff_ff   <= res_coeff_ff;
         rsp_exp_ff     <= res_exp_ff;
         rsp_found_ff   <= res_found_ff;
         rsp_dropped_ff <= terms_dropped;
      end
   end

   spm_term_store u_term_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (term_cmd),
      .rd_en   (term_rd_en),
      .rd_idx  (idx_ff),
      .rd_term (mac_term),
      .count   (term_count),
      .dropped (terms_dropped)
   );

   spm_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .mac_term     (mac_term),
      .mul_coeff    (coeff2_ff),
      .mul_exponent (exp2_ff),
      .clr          (clr_acc),
      .scan         (scan_acc),
      .rd_data      (sum_rd_data),
      .busy         (accum_busy)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_coeff    = rsp_coeff_ff;
   assign rsp_result_exponent = rsp_exp_ff;
   assign rsp_term_found      = rsp_found_ff;
   assign rsp_terms_dropped   = rsp_dropped_ff;

   `SPM_ASSERT_IMPL(a_emit_when_free, emit_load, !rsp_valid_ff || rsp_ready)
   `SPM_ASSERT_NEXT(a_fetch_scans, fetch_fire, state_ff == spm_pkg::ST_SCAN)
   `SPM_ASSERT_IMPL(a_found_nonzero, rsp_valid, rsp_term_found == (rsp_result_coeff != '0))

endmodule

### test/spm_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_result_checker
// Watches both channels of the sparse polynomial multiplier. It keeps its own
// copy of the term store, the product accumulator and the read cursor,
// predicts the term that each fetch transaction returns, and compares every
// response transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spm_result_checker
   import spm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic signed [COEFF_W-1:0]     req_term_coeff,
   input  logic [EXP_W-1:0]              req_term_exponent,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SUM_W-1:0]       rsp_result_coeff,
   input  logic [RES_EXP_W-1:0]          rsp_result_exponent,
   input  logic                          rsp_term_found,
   input  logic                          rsp_terms_dropped,
   output int                            failures,
   output int                            pending
);

   typedef struct packed {
      logic signed [SUM_W-1:0] coeff;
      logic [RES_EXP_W-1:0]    exponent;
      logic                    found;
      logic                    dropped;
   } fetched_term_type;

   localparam int TOP_CURSOR = SUM_SLOTS - 1;

   logic signed [COEFF_W-1:0] held_coeff    [MAX_TERMS];
   logic [EXP_W-1:0]          held_exponent [MAX_TERMS];
   int                        held_count;
   logic [SUM_W-1:0]          slot_sum      [SUM_SLOTS];
   int                        scan_cursor;
   logic                      dropped_flag;
   fetched_term_type          predicted_terms [$];
   int                        mismatch_count = 0;

   assign failures = mismatch_count;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string field, input logic [SUM_W-1:0] got,
                                  input logic [SUM_W-1:0] want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   // Empty the store and the accumulator, reset the cursor, drop the sticky flag
   task automatic clear_model();
      held_count   = 0;
      scan_cursor  = TOP_CURSOR;
      dropped_flag = 1'b0;
      foreach (slot_sum[s])
         slot_sum[s] = '0;
   endtask

   // Advance the predicted state by one request transaction
   task automatic apply_command(input func_type func, input logic signed [COEFF_W-1:0] coeff,
                                input logic [EXP_W-1:0] exponent);
      logic signed [2*COEFF_W-1:0] product;
      logic signed [SUM_W-1:0]     product_wide;
      int                          slot;
      fetched_term_type            term;
      case (func)
         FUNC_CLEAR: begin
            clear_model();
         end
         FUNC_LOAD_FIRST: begin
            scan_cursor = TOP_CURSOR;
            if (int'(exponent) <= MAX_EXPONENT) begin
               if (held_count >= MAX_TERMS) begin
                  dropped_flag = 1'b1;
               end else begin
                  held_coeff[held_count]    = coeff;
                  held_exponent[held_count] = exponent;
                  held_count++;
               end
            end
         end
         FUNC_LOAD_SECOND: begin
            scan_cursor = TOP_CURSOR;
            if (int'(exponent) <= MAX_EXPONENT) begin
               // Multiply by every held term and add into the slot of the exponent sum
               for (int i = 0; i < held_count; i++) begin
                  product      = held_coeff[i] * coeff;
                  product_wide = product;
                  slot         = int'(held_exponent[i]) + int'(exponent);
                  if (slot < SUM_SLOTS)
                     slot_sum[slot] = slot_sum[slot] + product_wide;
               end
            end
         end
         FUNC_FETCH: begin
            // Walk down from the cursor to the next nonzero sum
            term         = '0;
            term.dropped = dropped_flag;
            while (scan_cursor >= 0 && !term.found) begin
               slot = scan_cursor;
               scan_cursor--;
               if (slot_sum[slot] != '0) begin
                  term.coeff    = slot_sum[slot];
                  term.exponent = RES_EXP_W'(slot);
                  term.found    = 1'b1;
               end
            end
            predicted_terms.push_back(term);
         end
      endcase
   endtask

   always @(posedge clock) begin
      fetched_term_type want;
      if (reset) begin
         clear_model();
         predicted_terms.delete();
      end else begin
         // Check the response first: it always belongs to an older fetch
         if (rsp_valid && rsp_ready) begin
            if (predicted_terms.size() == 0) begin
               report_mismatch("response with no fetch waiting", rsp_result_coeff, '0);
            end else begin
               want = predicted_terms.pop_front();
               if (rsp_result_coeff !== want.coeff)
                  report_mismatch("result_coeff", rsp_result_coeff, want.coeff);
               if (rsp_result_exponent !== want.exponent)
                  report_mismatch("result_exponent", rsp_result_exponent, want.exponent);
               if (rsp_term_found !== want.found)
                  report_mismatch("term_found", rsp_term_found, want.found);
               if (rsp_terms_dropped !== want.dropped)
                  report_mismatch("terms_dropped", rsp_terms_dropped, want.dropped);
            end
         end
         if (req_valid && req_ready)
            apply_command(func_type'(req_func), req_term_coeff, req_term_exponent);
      end
      pending <= predicted_terms.size();
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the sparse polynomial multiplier. Drives a short directed
// sequence, an accumulator wrap-around run and then random polynomial
// sessions with noise, with random gaps on the request side and random stalls
// on the response side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import spm_pkg::*;

   localparam int ITEM_TARGET = 1050;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_func          = FUNC_CLEAR;
   logic signed [COEFF_W-1:0] req_term_coeff    = '0;
   logic [EXP_W-1:0]          req_term_exponent = '0;
   logic                      rsp_valid;
   logic                      rsp_ready         = 1'b0;
   logic signed [SUM_W-1:0]   rsp_result_coeff;
   logic [RES_EXP_W-1:0]      rsp_result_exponent;
   logic                      rsp_term_found;
   logic                      rsp_terms_dropped;
   int                        failures;
   int                        pending;
   bit                        calm              = 1'b0;
   int                        sent_items        = 0;

   always #10 clock = ~clock;

   sparse_polynomial_multiplier u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_term_coeff      (req_term_coeff),
      .req_term_exponent   (req_term_exponent),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_coeff    (rsp_result_coeff),
      .rsp_result_exponent (rsp_result_exponent),
      .rsp_term_found      (rsp_term_found),
      .rsp_terms_dropped   (rsp_terms_dropped)
   );

   spm_result_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_term_coeff      (req_term_coeff),
      .req_term_exponent   (req_term_exponent),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_coeff    (rsp_result_coeff),
      .rsp_result_exponent (rsp_result_exponent),
      .rsp_term_found      (rsp_term_found),
      .rsp_terms_dropped   (rsp_terms_dropped),
      .failures            (failures),
      .pending             (pending)
   );

   // Offer one request transaction after a random gap and hold it until taken
   task automatic send_command(input func_type func, input logic signed [COEFF_W-1:0] coeff,
                               input logic [EXP_W-1:0] exponent);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_term_coeff    <= coeff;
      req_term_exponent <= exponent;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   // Hold off the sender until every fetch has been answered
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Coefficients lean towards the extremes, zero and small values
   function automatic logic signed [COEFF_W-1:0] rand_coeff();
      case ($urandom_range(0, 9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3:       return COEFF_W'($urandom_range(0, 6)) - 16'sd3;
         default: return COEFF_W'($urandom);
      endcase
   endfunction

   // Occasionally slip in a fully random transaction
   task automatic send_noise();
      if ($urandom_range(0, 11) == 0)
         send_command(func_type'($urandom_range(0, 3)), COEFF_W'($urandom), EXP_W'($urandom));
   endtask

   // Response side: stall each result for a random number of cycles
   initial begin : response_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0)
               rsp_ready <= 1'b0;
         end else if (rsp_valid && !rsp_ready) begin
            if (stall <= 1)
               rsp_ready <= 1'b1;
            stall--;
         end
      end
   end

   initial begin : stimulus
      int n_first;
      int n_second;
      int n_fetch;
      int span;
      int base;
      logic [EXP_W-1:0] wrap_first_exp;
      logic [EXP_W-1:0] wrap_second_exp;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty fetch, extremes, zero term, restart after a load
      send_command(FUNC_FETCH, '0, '0);
      send_command(FUNC_LOAD_FIRST, 16'sh7FFF, 8'd255);
      send_command(FUNC_LOAD_FIRST, 16'sh8000, 8'd0);
      send_command(FUNC_LOAD_FIRST, '0, 8'd17);
      send_command(FUNC_LOAD_SECOND, 16'sh8000, 8'd255);
      send_command(FUNC_FETCH, '0, '0);
      send_command(FUNC_FETCH, '0, '0);
      send_command(FUNC_LOAD_FIRST, 16'sd1, 8'd128);
      send_command(FUNC_FETCH, '0, '0);
      send_command(FUNC_LOAD_SECOND, 16'sh7FFF, 8'd0);
      repeat (6) send_command(FUNC_FETCH, 16'sh7FFF, 8'hFF);
      // Clear, then a second term with nothing to multiply
      send_command(FUNC_CLEAR, 16'sh7FFF, 8'hFF);
      send_command(FUNC_LOAD_SECOND, 16'sd1234, 8'd3);
      send_command(FUNC_FETCH, '0, '0);
      // Products that cancel to zero are not returned
      send_command(FUNC_LOAD_FIRST, -16'sd1, 8'd255);
      send_command(FUNC_LOAD_FIRST, 16'sd1, 8'd255);
      send_command(FUNC_LOAD_SECOND, 16'sd5, 8'd10);
      send_command(FUNC_FETCH, '0, '0);
      wait_drain();

      // Overfill the store and drive one sum round past 2^44: each second
      // term adds 64 * 2^30 = 2^36, so more than 256 of them are needed
      n_second        = $urandom_range(260, 300);
      wrap_first_exp  = EXP_W'($urandom);
      wrap_second_exp = EXP_W'($urandom);
      send_command(FUNC_CLEAR, '0, '0);
      repeat (MAX_TERMS + 2) send_command(FUNC_LOAD_FIRST, 16'sh8000, wrap_first_exp);
      repeat (n_second) send_command(FUNC_LOAD_SECOND, 16'sh8000, wrap_second_exp);
      repeat (3) send_command(FUNC_FETCH, '0, '0);
      // The sticky flag must fall with a clear
      send_command(FUNC_CLEAR, '0, '0);
      send_command(FUNC_FETCH, '0, '0);

      // Random polynomial sessions
      while (sent_items < ITEM_TARGET) begin
         n_first  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
         n_second = $urandom_range(1, 8);
         span     = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(0, 7);
         base     = $urandom_range(0, 255 - span);
         calm     = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0)
            wait_drain();
         if ($urandom_range(0, 4) != 0)
            send_command(FUNC_CLEAR, rand_coeff(), EXP_W'($urandom));
         for (int i = 0; i < n_first; i++) begin
            send_noise();
            send_command(FUNC_LOAD_FIRST, rand_coeff(), EXP_W'(base + $urandom_range(0, span)));
         end
         for (int i = 0; i < n_second; i++) begin
            send_noise();
            // Now and then a late first term, missed by the earlier second terms
            if ($urandom_range(0, 9) == 0)
               send_command(FUNC_LOAD_FIRST, rand_coeff(), EXP_W'(base + $urandom_range(0, span)));
            send_command(FUNC_LOAD_SECOND, rand_coeff(), EXP_W'(base + $urandom_range(0, span)));
         end
         n_fetch = ((n_first * n_second < 24) ? n_first * n_second : 24) + $urandom_range(1, 3);
         for (int i = 0; i < n_fetch; i++) begin
            send_noise();
            send_command(FUNC_FETCH, rand_coeff(), EXP_W'($urandom));
         end
      end

      // Drain, let the last loads settle, then give the verdict
      calm = 1'b0;
      wait_drain();
      repeat (600) @(posedge clock);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin : watchdog
      #50_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/spm_pkg.sv
hw/rtl/spm_term_store.sv
hw/rtl/spm_accum.sv
hw/rtl/sparse_polynomial_multiplier.sv
test/spm_result_checker.sv
test/tb.sv
